/* design/scanline_pixel_bit_packer_unit_defines.svh */
// ----------------------------------------------------------------------------
// scanline pixel bit packer assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SCANLINE_PIXEL_BIT_PACKER_UNIT_DEFINES_SVH
`define SCANLINE_PIXEL_BIT_PACKER_UNIT_DEFINES_SVH

`ifndef SYNTH

// check outside reset
`define SPBP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spbp assertion failed");

// check at every edge, reset included
`define SPBP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spbp assertion failed");

`else

`define SPBP_ASSERT(lbl, clk, rst_n, prop)
`define SPBP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* design/spbp_pkg.sv */
// ----------------------------------------------------------------------------
// spbp_pkg
// shared types and constants of the scanline pixel bit packer
// ----------------------------------------------------------------------------
package spbp_pkg;

    localparam int PixelW    = 8;
    localparam int ColW      = 14;
    localparam int WidthW    = 15;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 15;
    localparam int FillW     = 3;
    localparam int MaxWidth  = 16384;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DEPTH_CODE  = 2'd0,
        REG_GRAY_MODE   = 2'd1,
        REG_IMAGE_WIDTH = 2'd2,
        REG_NONE        = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        DEPTH_1 = 2'd0,
        DEPTH_2 = 2'd1,
        DEPTH_4 = 2'd2,
        DEPTH_8 = 2'd3
    } t_depth;

    typedef struct packed {
        t_depth              depth;
        logic                gray;
        logic [WidthW-1:0]   eff_width;
        logic                clear;
    } t_cfg;

endpackage

/* design/spbp_ifs.sv */
// ----------------------------------------------------------------------------
// spbp channel interfaces
// valid/ready channels for pixels, packed results and register writes
// ----------------------------------------------------------------------------
interface spbp_pix_if;
    logic                          valid;
    logic                          ready;
    logic [spbp_pkg::PixelW-1:0]   pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface spbp_out_if;
    logic                          valid;
    logic                          ready;
    logic [spbp_pkg::PixelW-1:0]   packed_byte;
    logic                          row_end;

    modport source (output valid, output packed_byte, output row_end, input ready);
    modport sink   (input valid, input packed_byte, input row_end, output ready);
endinterface

interface spbp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spbp_pkg::CfgIdxW-1:0]   index;
    logic [spbp_pkg::CfgDataW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/spbp_cfg.sv */
// ----------------------------------------------------------------------------
// spbp_cfg
// register file: depth, gray mode and clamped scanline width
// ----------------------------------------------------------------------------
module spbp_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    spbp_cfg_if.sink            i_cfg,
    output spbp_pkg::t_cfg      o_cfg
);

    spbp_pkg::t_depth                 r_depth;
    logic                             r_gray;
    logic [spbp_pkg::WidthW-1:0]      r_width;
    logic [spbp_pkg::WidthW-1:0]      n_width;
    logic                             wr;
    logic                             clear_req;
    spbp_pkg::t_reg_idx               idx;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid;
    assign idx         = spbp_pkg::t_reg_idx'(i_cfg.index);

    // any write to a known register restarts the row at the same edge
    assign clear_req   = wr && (idx != spbp_pkg::REG_NONE);

    // zero reads as one, above maximum saturates
    always_comb begin
        priority if (i_cfg.data[spbp_pkg::WidthW-1:0] == '0) begin
            n_width = spbp_pkg::WidthW'(1);
        end else if (i_cfg.data[spbp_pkg::WidthW-1:0]
                     > spbp_pkg::WidthW'(spbp_pkg::MaxWidth)) begin
            n_width = spbp_pkg::WidthW'(spbp_pkg::MaxWidth);
        end else begin
            n_width = i_cfg.data[spbp_pkg::WidthW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= spbp_pkg::DEPTH_8;
            r_gray  <= 1'b0;
            r_width <= spbp_pkg::WidthW'(1);
        end else begin
            if (wr) begin
                unique case (idx)
                    spbp_pkg::REG_DEPTH_CODE: begin
                        r_depth <= spbp_pkg::t_depth'(i_cfg.data[1:0]);
                    end
                    spbp_pkg::REG_GRAY_MODE: begin
                        r_gray  <= i_cfg.data[0];
                    end
                    spbp_pkg::REG_IMAGE_WIDTH: begin
                        r_width <= n_width;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cfg.depth     = r_depth;
    assign o_cfg.gray      = r_gray;
    assign o_cfg.eff_width = r_width;
    assign o_cfg.clear     = clear_req;

endmodule

/* design/spbp_pack.sv */
// ----------------------------------------------------------------------------
// spbp_pack
// row state and packing datapath: sample select, shift into byte, row end
// ----------------------------------------------------------------------------
`include "scanline_pixel_bit_packer_unit_defines.svh"

module spbp_pack (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spbp_pkg::t_cfg               i_cfg,
    input  logic                         i_step,
    input  logic [spbp_pkg::PixelW-1:0]  i_pixel,
    output logic                         o_emit,
    output logic [spbp_pkg::PixelW-1:0]  o_byte,
    output logic                         o_row_end
);

    logic [spbp_pkg::PixelW-1:0]  r_acc;
    logic [spbp_pkg::FillW-1:0]   r_fill;
    logic [spbp_pkg::ColW-1:0]    r_col;

    logic [spbp_pkg::PixelW-1:0]  n_acc;
    logic [spbp_pkg::FillW-1:0]   n_fill;
    logic [spbp_pkg::ColW-1:0]    n_col;

    logic [3:0]                   bits;
    logic [3:0]                   per_byte;
    logic [spbp_pkg::FillW-1:0]   slot;
    logic [3:0]                   used;
    logic [3:0]                   shift;
    logic [spbp_pkg::PixelW-1:0]  mask;
    logic [spbp_pkg::PixelW-1:0]  sample;
    logic [spbp_pkg::PixelW-1:0]  acc_new;
    logic [spbp_pkg::FillW:0]     fill_new;
    logic [spbp_pkg::WidthW-1:0]  col_inc;
    logic                         last;
    logic                         full;

    assign col_inc = {1'b0, r_col} + spbp_pkg::WidthW'(1);
    assign last    = col_inc >= i_cfg.eff_width;

    always_comb begin
        bits     = 4'd1 << i_cfg.depth;
        per_byte = 4'd8 >> i_cfg.depth;
        mask     = 8'((9'd1 << bits) - 9'd1);
        if (i_cfg.gray) begin
            sample = i_pixel >> (4'd8 - bits);
        end else begin
            sample = i_pixel & mask;
        end
        if ({1'b0, r_fill} >= per_byte) begin
            slot = spbp_pkg::FillW'(per_byte - 4'd1);
        end else begin
            slot = r_fill;
        end
        fill_new = {1'b0, slot} + 4'd1;
        used     = fill_new << i_cfg.depth;
        shift    = 4'd8 - used;
        acc_new  = r_acc | 8'(sample << shift);
        full     = fill_new == per_byte;
    end

    always_comb begin
        o_row_end = last;
        if (i_cfg.depth == spbp_pkg::DEPTH_8) begin
            o_emit = 1'b1;
            o_byte = i_pixel;
            n_acc  = '0;
            n_fill = '0;
        end else begin
            o_emit = full || last;
            o_byte = acc_new;
            n_acc  = (full || last) ? '0 : acc_new;
            n_fill = (full || last) ? '0 : fill_new[spbp_pkg::FillW-1:0];
        end
        n_col = last ? '0 : col_inc[spbp_pkg::ColW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fill <= '0;
            r_col  <= '0;
        end else if (i_cfg.clear) begin
            r_acc  <= '0;
            r_fill <= '0;
            r_col  <= '0;
        end else if (i_step) begin
            r_acc  <= n_acc;
            r_fill <= n_fill;
            r_col  <= n_col;
        end
    end

    `SPBP_ASSERT(a_fill_below_per_byte, i_clk, i_rst_n, {1'b0, r_fill} < per_byte)
    `SPBP_ASSERT(a_col_below_width, i_clk, i_rst_n, {1'b0, r_col} < i_cfg.eff_width)
    `SPBP_ASSERT(a_row_end_restarts, i_clk, i_rst_n, (i_step && last) |=> (r_col == '0 && r_fill == '0 && r_acc == '0))
    `SPBP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_col == '0 && r_fill == '0))

endmodule

/* design/scanline_pixel_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// scanline_pixel_bit_packer_unit
// packs 8-bit pixels into 1, 2 or 4 bit scanline bytes, or passes them through
// ----------------------------------------------------------------------------
// channel   dir  payload                    role
// i_pix     in   pixel_value[7:0]           one pixel per request
// o_res     out  packed_byte[7:0], row_end  packed byte, last of row flagged
// i_cfg     in   index[1:0], data[14:0]     register write, always ready
//
// one pixel per cycle sustained while the result is not stalled; a pixel passes
// the input register, then packing logic into the result register
// a pixel that completes no byte retires without a result
// a stalled result holds the result register; the input register refills
// as soon as its pixel moves on
// synchronous active-low reset; a write to a known register restarts the row
// ----------------------------------------------------------------------------
module scanline_pixel_bit_packer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spbp_pix_if.sink      i_pix,
    spbp_out_if.source    o_res,
    spbp_cfg_if.sink      i_cfg
);

    spbp_pkg::t_cfg                 cfg;

    logic                           r_in_valid;
    logic [spbp_pkg::PixelW-1:0]    r_in_pixel;
    logic                           r_out_valid;
    logic [spbp_pkg::PixelW-1:0]    r_out_byte;
    logic                           r_out_row_end;

    logic                           step;
    logic                           emit;
    logic [spbp_pkg::PixelW-1:0]    pk_byte;
    logic                           pk_row_end;

    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_in_valid || step;

    spbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    spbp_pack u_pack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step    (step),
        .i_pixel   (r_in_pixel),
        .o_emit    (emit),
        .o_byte    (pk_byte),
        .o_row_end (pk_row_end)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in_pixel <= i_pix.pixel_value;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_byte    <= pk_byte;
            r_out_row_end <= pk_row_end;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.packed_byte = r_out_byte;
    assign o_res.row_end     = r_out_row_end;

endmodule
